FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Types and constants of the pre-colored bipartite checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pbc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;

  localparam int VTX_W   = $clog2(MAX_VERTICES);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int ETOT_W  = $clog2(MAX_EDGES + 1);
  localparam int IDX_W   = (ETOT_W > VTX_W + 1) ? ETOT_W : VTX_W + 1;

  localparam int REQ_W  = 2;
  localparam int VNUM_W = 11;
  localparam int CNT_W  = 11;
  localparam int ERR_W  = 2;
  localparam int SIDE_W = 2;

  localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SIDE1  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SIDE2  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_NONE = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_ONE  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_TWO  = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_SUM  = 2'd3;

  typedef struct packed {
    logic load_item;
    logic touch_b;
    logic force_wr;
    logic clear_wr;
    logic idx_clr;
    logic idx_inc;
    logic edge_rd;
    logic find_a;
    logic find_b;
    logic find_v;
    logic find_step;
    logic union_wr;
    logic need_rd;
    logic need_chk;
    logic vert_rd;
    logic set_fail;
    logic out_load;
  } pbc_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic a_ok;
    logic b_ok;
    logic full;
    logic conflict;
    logic edge_done;
    logic vert_done;
    logic clear_last;
    logic root_hit;
    logic union_bad;
    logic iso_bad;
    logic side_zero;
    logic need_bad;
    logic out_busy;
  } pbc_stat_t;

endpackage

`default_nettype wire

FILE: src/pbc_ctrl.sv
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer: loading, edge union walk, vertex scan, answer and store clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pbc_ctrl import pbc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire pbc_stat_t st,
  output pbc_cmd_t       cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TOUCHB = 4'd2;
  localparam logic [3:0] S_FORCE  = 4'd3;
  localparam logic [3:0] S_FIN    = 4'd4;
  localparam logic [3:0] S_E_RD   = 4'd5;
  localparam logic [3:0] S_E_GO   = 4'd6;
  localparam logic [3:0] S_FIND   = 4'd7;
  localparam logic [3:0] S_V_RD   = 4'd8;
  localparam logic [3:0] S_V_CHK  = 4'd9;
  localparam logic [3:0] S_NEED   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_V = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          case (st.kind)
            REQ_EDGE: begin
              if (st.a_ok && st.b_ok && !st.full) state_nxt = S_TOUCHB;
            end
            REQ_SIDE1, REQ_SIDE2: begin
              if (st.a_ok) state_nxt = S_FORCE;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_TOUCHB: begin
        cmd.touch_b = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_FORCE: begin
        cmd.force_wr = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_FIN: begin
        if (st.conflict) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_E_RD;
        end
      end
      S_E_RD: begin
        if (st.edge_done) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_V_RD;
        end else begin
          cmd.edge_rd = 1'b1;
          state_nxt   = S_E_GO;
        end
      end
      S_E_GO: begin
        cmd.find_a = 1'b1;
        ph_nxt     = PH_A;
        state_nxt  = S_FIND;
      end
      S_FIND: begin
        if (!st.root_hit) begin
          cmd.find_step = 1'b1;
        end else begin
          case (ph_r)
            PH_A: begin
              cmd.find_b = 1'b1;
              ph_nxt     = PH_B;
            end
            PH_B: begin
              if (st.union_bad) begin
                cmd.set_fail = 1'b1;
                state_nxt    = S_OUT;
              end else begin
                cmd.union_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_nxt    = S_E_RD;
              end
            end
            default: begin
              cmd.need_rd = 1'b1;
              state_nxt   = S_NEED;
            end
          endcase
        end
      end
      S_V_RD: begin
        if (st.vert_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.vert_rd = 1'b1;
          state_nxt   = S_V_CHK;
        end
      end
      S_V_CHK: begin
        if (st.iso_bad) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_OUT;
        end else if (st.side_zero) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_V_RD;
        end else begin
          cmd.find_v = 1'b1;
          ph_nxt     = PH_V;
          state_nxt  = S_FIND;
        end
      end
      S_NEED: begin
        if (st.need_bad) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.need_chk = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_V_RD;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ph_r    <= PH_A;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  `PBC_ASSERT_NXT(a_finish_blocks, accept && st.kind == REQ_FINISH, !in_tready, "finish word not followed by busy")
  `PBC_ASSERT_IMP(a_load_only_on_accept, cmd.load_item, in_tvalid, "item loaded without valid")
  `PBC_ASSERT_NXT(a_clear_leads_idle, state_r == S_CLEAR && st.clear_last, in_tready, "clear sweep did not end in idle")

endmodule

`default_nettype wire

FILE: src/pbc_dpath.sv
// ----------------------------------------------------------------------------
// pbc_dpath
// Vertex, edge and union-find stores, walk registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pbc_dpath import pbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic [REQ_W-1:0]  in_kind,
  input  wire logic [VNUM_W-1:0] in_va,
  input  wire logic [VNUM_W-1:0] in_vb,
  input  wire pbc_cmd_t          cmd,
  output pbc_stat_t              st,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic                   out_verdict,
  output logic [ERR_W-1:0]       out_error
);

  // Stores
  logic [SIDE_W-1:0]  side_mem  [MAX_VERTICES];
  logic               touch_mem [MAX_VERTICES];
  logic [VTX_W:0]     link_mem  [MAX_VERTICES];
  logic [SIDE_W-1:0]  need_mem  [MAX_VERTICES];
  logic [2*VTX_W-1:0] edge_mem  [MAX_EDGES];

  logic [SIDE_W-1:0]  side_q;
  logic               touch_q;
  logic [VTX_W:0]     link_q;
  logic [SIDE_W-1:0]  need_q;
  logic [2*VTX_W-1:0] edge_q;

  logic [CNT_W-1:0]  vcount_r;
  logic [ETOT_W-1:0] edge_total_r;
  logic              conflict_r;
  logic [ERR_W-1:0]  err_r;
  logic              fail_r;
  logic [IDX_W-1:0]  idx_r;

  logic [REQ_W-1:0]  kind_r;
  logic [VTX_W-1:0]  a_r, b_r, eb_r, x_r, ru_r, root_r;
  logic              acc_r, pu_r;
  logic [SIDE_W-1:0] sv_r, need_r;

  logic              out_valid_r, verdict_r;
  logic [ERR_W-1:0]  err_out_r;

  logic [VNUM_W-1:0] va_m1, vb_m1;
  logic [VTX_W-1:0]  va_addr, vb_addr, idx_v, link_up, edge_a;
  logic              link_par;
  logic              a_ok, b_ok, full, edge_ok_ld;
  logic [SIDE_W-1:0] need_v;
  logic              root_hit;

  assign va_m1   = in_va - VNUM_W'(1);
  assign vb_m1   = in_vb - VNUM_W'(1);
  assign va_addr = va_m1[VTX_W-1:0];
  assign vb_addr = vb_m1[VTX_W-1:0];
  assign idx_v   = idx_r[VTX_W-1:0];
  assign link_up  = link_q[VTX_W:1];
  assign link_par = link_q[0];
  assign edge_a   = edge_q[VTX_W-1:0];

  assign a_ok = (in_va != '0) && (in_va <= vcount_r) && (32'(in_va) <= 32'(MAX_VERTICES));
  assign b_ok = (in_vb != '0) && (in_vb <= vcount_r) && (32'(in_vb) <= 32'(MAX_VERTICES));
  assign full = (32'(edge_total_r) == 32'(MAX_EDGES));
  assign edge_ok_ld = cmd.load_item && (in_kind == REQ_EDGE) && a_ok && b_ok && !full;
  assign root_hit = (link_up == x_r);
  assign need_v = (((sv_r == SIDE_TWO) ? 1'b1 : 1'b0) ^ acc_r) ? SIDE_TWO : SIDE_ONE;

  always_comb begin
    st            = '0;
    st.kind       = in_kind;
    st.a_ok       = a_ok;
    st.b_ok       = b_ok;
    st.full       = full;
    st.conflict   = conflict_r;
    st.edge_done  = (idx_r == IDX_W'(edge_total_r));
    st.vert_done  = (32'(idx_r) == 32'(MAX_VERTICES));
    st.clear_last = (32'(idx_r) == 32'(MAX_VERTICES - 1));
    st.root_hit   = root_hit;
    st.union_bad  = (x_r == ru_r) && (acc_r == pu_r);
    st.iso_bad    = (idx_r < IDX_W'(vcount_r)) && (side_q == SIDE_NONE) && !touch_q;
    st.side_zero  = (side_q == SIDE_NONE);
    st.need_bad   = (need_q != SIDE_NONE) && (need_q != need_r);
    st.out_busy   = out_valid_r && !out_tready;
  end

  // Vertex side store
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      side_mem[idx_v] <= SIDE_NONE;
    end else if (cmd.force_wr) begin
      side_mem[a_r] <= kind_r;
    end
    if (cmd.load_item) begin
      side_q <= side_mem[va_addr];
    end else if (cmd.vert_rd) begin
      side_q <= side_mem[idx_v];
    end
  end

  // Touched flags
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      touch_mem[idx_v] <= 1'b0;
    end else if (edge_ok_ld) begin
      touch_mem[va_addr] <= 1'b1;
    end else if (cmd.touch_b) begin
      touch_mem[b_r] <= 1'b1;
    end
    if (cmd.vert_rd) begin
      touch_q <= touch_mem[idx_v];
    end
  end

  // Edge list
  always_ff @(posedge clk) begin
    if (edge_ok_ld) begin
      edge_mem[edge_total_r[EDGE_AW-1:0]] <= {vb_addr, va_addr};
    end
    if (cmd.edge_rd) begin
      edge_q <= edge_mem[idx_r[EDGE_AW-1:0]];
    end
  end

  // Parity union-find links: parent and parity to parent
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      link_mem[idx_v] <= {idx_v, 1'b0};
    end else if (cmd.union_wr && (x_r != ru_r)) begin
      link_mem[ru_r] <= {x_r, pu_r ^ acc_r ^ 1'b1};
    end
    if (cmd.find_a) begin
      link_q <= link_mem[edge_a];
    end else if (cmd.find_b) begin
      link_q <= link_mem[eb_r];
    end else if (cmd.find_v) begin
      link_q <= link_mem[idx_v];
    end else if (cmd.find_step) begin
      link_q <= link_mem[link_up];
    end
  end

  // Side required of each component root
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      need_mem[idx_v] <= SIDE_NONE;
    end else if (cmd.need_chk && (need_q == SIDE_NONE)) begin
      need_mem[root_r] <= need_r;
    end
    if (cmd.need_rd) begin
      need_q <= need_mem[x_r];
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      a_r    <= va_addr;
      b_r    <= vb_addr;
    end
    if (cmd.find_a) begin
      x_r   <= edge_a;
      acc_r <= 1'b0;
      eb_r  <= edge_q[2*VTX_W-1:VTX_W];
    end else if (cmd.find_b) begin
      ru_r  <= x_r;
      pu_r  <= acc_r;
      x_r   <= eb_r;
      acc_r <= 1'b0;
    end else if (cmd.find_v) begin
      x_r   <= idx_v;
      acc_r <= 1'b0;
      sv_r  <= side_q;
    end else if (cmd.find_step) begin
      x_r   <= link_up;
      acc_r <= acc_r ^ link_par;
    end
    if (cmd.need_rd) begin
      root_r <= x_r;
      need_r <= need_v;
    end
    if (cmd.out_load) begin
      verdict_r <= !fail_r;
      err_out_r <= err_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r     <= CNT_W'(1);
      edge_total_r <= '0;
      conflict_r   <= 1'b0;
      err_r        <= ERR_NONE;
      fail_r       <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc || cmd.clear_wr) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.clear_wr) begin
        edge_total_r <= '0;
        conflict_r   <= 1'b0;
        err_r        <= ERR_NONE;
        fail_r       <= 1'b0;
      end else begin
        if (edge_ok_ld) edge_total_r <= edge_total_r + ETOT_W'(1);
        if (cmd.set_fail) fail_r <= 1'b1;
        if (cmd.force_wr && (side_q == SIDE_SUM - kind_r)) conflict_r <= 1'b1;
        if (cmd.load_item && (err_r == ERR_NONE)) begin
          if (in_kind == REQ_EDGE) begin
            if (!a_ok || !b_ok) err_r <= ERR_RANGE;
            else if (full) err_r <= ERR_OVERFLOW;
          end else if (in_kind != REQ_FINISH) begin
            if (!a_ok) err_r <= ERR_RANGE;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_error   = err_out_r;

  `PBC_ASSERT_IMP(a_out_slot_free, cmd.out_load, !out_valid_r || out_tready, "result overwritten")
  `PBC_ASSERT_IMP(a_step_not_root, cmd.find_step, !root_hit, "find stepped past root")
  `PBC_ASSERT_NXT(a_edge_bound, edge_ok_ld, 32'(edge_total_r) <= 32'(MAX_EDGES), "edge count overran")

endmodule

`default_nettype wire

FILE: src/precolored_bipartite_check_top.sv
// Pre-colored bipartite checker.
// Input words (in_*) carry an edge, a forced side for one vertex, or a
// finish request; in_tuser holds the request kind. Result words (out_*) come
// only for finish requests: verdict 1 when a two-coloring exists that meets
// every edge and every forced side and every vertex within the count lies
// on an edge or is forced, plus the first error seen since the last answer.
// cfg_wr_en/cfg_wr_data set the vertex count. A dropped load word leaves the
// block idle; a stored edge or forced side takes a second state (a touch
// write for vertex b, or the side write after its read). A finish walks the
// edge list through a parity union-find, one link read per cycle, then scans
// all 1024 vertices, checking each forced vertex against its root, then
// gives the answer word.
// After each answer, and after reset, a clearing pass resets the vertex
// stores; in_tready stays low meanwhile. Configuration writes are taken at
// any time.
// A stalled receiver holds the result word in its register; the block
// clears and takes new words meanwhile; a next answer waits till it is taken.
// ----------------------------------------------------------------------------
// precolored_bipartite_check_top
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module precolored_bipartite_check_top import pbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [23:0]       in_tdata,   // vertex_a[10:0], vertex_b[21:11], zero
  input  wire logic [REQ_W-1:0]  in_tuser,   // req_type[1:0]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata   // verdict[0], error[2:1], zero
);

  pbc_cmd_t         cmd;
  pbc_stat_t        st;
  logic             verdict;
  logic [ERR_W-1:0] error_code;

  pbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pbc_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_kind     (in_tuser),
    .in_va       (in_tdata[VNUM_W-1:0]),
    .in_vb       (in_tdata[2*VNUM_W-1:VNUM_W]),
    .cmd         (cmd),
    .st          (st),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_verdict (verdict),
    .out_error   (error_code)
  );

  assign out_tdata = {5'b0, error_code, verdict};

endmodule

`default_nettype wire
